FILE: rtl/core/ball_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear angle light lookup package
// Shared widths, constants and the words passed between the pipeline parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ball_pkg;

  localparam int ANGLE_W    = 17;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_BITS   = 8;
  localparam int LEVEL_BITS = 16;
  localparam int BLEND_W    = 9;
  localparam int BANK_AW    = 2 * (IDX_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int WT_W       = 2 * FRAC_BITS + 1;
  localparam int PROD_W     = LEVEL_BITS + 2 * FRAC_BITS;

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(256);
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  wr;
    logic                  last;
    logic                  same;
    logic [BLEND_W-1:0]    weight;
    logic [IDX_BITS-1:0]   pidx;
    logic [FRAC_BITS-1:0]  pfrac;
    logic [IDX_BITS-1:0]   yidx;
    logic [FRAC_BITS-1:0]  yfrac;
    logic [LEVEL_BITS-1:0] wdata;
  } slot_t;

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  same;
    logic [BLEND_W-1:0]    weight;
    logic [LEVEL_BITS-1:0] level;
  } samp_t;

endpackage

`default_nettype wire

FILE: rtl/core/ball_sampler.sv
// ----------------------------------------------------------------------------
// Bilinear sampler
// Four parity banks of the light table, read for one bilinear sample per
// cycle, then weighted, summed, rounded and raised to the floor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ball_sampler import ball_pkg::*; (
  input  wire                  clk,
  input  wire                  rst,
  input  slot_t                slot,
  input  wire [LEVEL_BITS-1:0] min_level,
  output samp_t                samp
);

  logic [LEVEL_BITS-1:0] bank0 [BANK_DEPTH];
  logic [LEVEL_BITS-1:0] bank1 [BANK_DEPTH];
  logic [LEVEL_BITS-1:0] bank2 [BANK_DEPTH];
  logic [LEVEL_BITS-1:0] bank3 [BANK_DEPTH];

  logic [IDX_BITS-1:0]  pidx1, yidx1;
  logic [BANK_AW-1:0]   raddr [4];
  logic [BANK_AW-1:0]   waddr;
  logic [3:0]           wen;
  logic [FRAC_BITS:0]   pa, pb, ya, yb;
  logic [2*FRAC_BITS+1:0] wt_full [4];

  logic                  v2, last2, same2, p0, y0;
  logic [BLEND_W-1:0]    weight2;
  logic [LEVEL_BITS-1:0] rd [4];
  logic [WT_W-1:0]       wt2 [4];

  logic                  v3, last3, same3;
  logic [BLEND_W-1:0]    weight3;
  logic [PROD_W-1:0]     prod3 [4];
  logic [LEVEL_BITS-1:0] r00, r10, r01, r11;
  logic [PROD_W+LEVEL_BITS+WT_W-1:0] mul_full [4];

  logic [PROD_W+1:0]     sum;
  logic [LEVEL_BITS-1:0] rounded;

  assign pidx1 = pidx_inc(slot.pidx);
  assign yidx1 = pidx_inc(slot.yidx);

  function automatic logic [IDX_BITS-1:0] pidx_inc(input logic [IDX_BITS-1:0] v);
    pidx_inc = v + IDX_BITS'(1);
  endfunction

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {((slot.pidx[0] == b[1]) ? slot.pidx[IDX_BITS-1:1] : pidx1[IDX_BITS-1:1]),
                  ((slot.yidx[0] == b[0]) ? slot.yidx[IDX_BITS-1:1] : yidx1[IDX_BITS-1:1])};
      wen[b] = slot.valid && slot.wr && (slot.pidx[0] == b[1]) && (slot.yidx[0] == b[0]);
    end
    waddr = {slot.pidx[IDX_BITS-1:1], slot.yidx[IDX_BITS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (wen[0]) begin
      bank0[waddr] <= slot.wdata;
    end
    rd[0] <= bank0[raddr[0]];
  end

  always_ff @(posedge clk) begin
    if (wen[1]) begin
      bank1[waddr] <= slot.wdata;
    end
    rd[1] <= bank1[raddr[1]];
  end

  always_ff @(posedge clk) begin
    if (wen[2]) begin
      bank2[waddr] <= slot.wdata;
    end
    rd[2] <= bank2[raddr[2]];
  end

  always_ff @(posedge clk) begin
    if (wen[3]) begin
      bank3[waddr] <= slot.wdata;
    end
    rd[3] <= bank3[raddr[3]];
  end

  // Weights in order r00, r10, r01, r11.
  always_comb begin
    pb = {1'b0, slot.pfrac};
    pa = (FRAC_BITS+1)'(1 << FRAC_BITS) - pb;
    yb = {1'b0, slot.yfrac};
    ya = (FRAC_BITS+1)'(1 << FRAC_BITS) - yb;
    wt_full[0] = pa * ya;
    wt_full[1] = pb * ya;
    wt_full[2] = pa * yb;
    wt_full[3] = pb * yb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= slot.valid && !slot.wr;
    end
    last2   <= slot.last;
    same2   <= slot.same;
    weight2 <= slot.weight;
    p0      <= slot.pidx[0];
    y0      <= slot.yidx[0];
    for (int i = 0; i < 4; i++) begin
      wt2[i] <= wt_full[i][WT_W-1:0];
    end
  end

  always_comb begin
    r00 = rd[{p0, y0}];
    r10 = rd[{~p0, y0}];
    r01 = rd[{p0, ~y0}];
    r11 = rd[{~p0, ~y0}];
    mul_full[0] = r00 * wt2[0];
    mul_full[1] = r10 * wt2[1];
    mul_full[2] = r01 * wt2[2];
    mul_full[3] = r11 * wt2[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    last3   <= last2;
    same3   <= same2;
    weight3 <= weight2;
    for (int i = 0; i < 4; i++) begin
      prod3[i] <= mul_full[i][PROD_W-1:0];
    end
  end

  always_comb begin
    sum = (PROD_W+2)'(prod3[0]) + (PROD_W+2)'(prod3[1]) + (PROD_W+2)'(prod3[2])
        + (PROD_W+2)'(prod3[3]) + (PROD_W+2)'(1 << (2 * FRAC_BITS - 1));
    rounded = sum[PROD_W-1:2*FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp.valid <= 1'b0;
    end else begin
      samp.valid <= v3;
    end
    samp.last   <= last3;
    samp.same   <= same3;
    samp.weight <= weight3;
    samp.level  <= (rounded < min_level) ? min_level : rounded;
  end

endmodule

`default_nettype wire

FILE: rtl/core/bilinear_angle_light_lookup_core.sv
// ----------------------------------------------------------------------------
// Bilinear angle light lookup core
// A table write is issued as one slot; a lookup as two, one bilinear sample
// for each angle pair, and its light word appears on light with done high
// after the issue, slot, sampler and blend registers. busy is high while a
// lookup's second sample waits, as the four table banks give one sample per
// cycle. The receiver cannot stall it, and no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_angle_light_lookup_core import ball_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire                        command,
  input  wire [IDX_BITS-1:0]         table_row,
  input  wire [IDX_BITS-1:0]         table_col,
  input  wire [LEVEL_BITS-1:0]       table_value,
  input  wire signed [ANGLE_W-1:0]   pitch_a,
  input  wire signed [ANGLE_W-1:0]   yaw_a,
  input  wire signed [ANGLE_W-1:0]   pitch_b,
  input  wire signed [ANGLE_W-1:0]   yaw_b,
  input  wire [BLEND_W-1:0]          blend,
  input  wire signed [ANGLE_W-1:0]   model_pitch,
  input  wire signed [ANGLE_W-1:0]   model_yaw,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [LEVEL_BITS-1:0]       cfg_data,
  output logic                       done,
  output logic [LEVEL_BITS-1:0]      light
);

  logic                  item_valid, phase, cmd;
  logic [IDX_BITS-1:0]   row, col;
  logic [LEVEL_BITS-1:0] value;
  logic [ANGLE_W-1:0]    pa, ya, pb, yb, mp, my;
  logic [BLEND_W-1:0]    weight;
  logic [LEVEL_BITS-1:0] min_level;
  logic                  accept;

  logic [ANGLE_W-1:0]    pn, yn;
  logic [ANGLE_W:0]      psum, pabs;
  logic [ANGLE_W-1:0]    yabs;
  logic [ANGLE_W+1:0]    ysum;
  slot_t                 slot_next, slot;
  samp_t                 samp;

  logic [LEVEL_BITS-1:0]         l1_hold, l1;
  logic [LEVEL_BITS+BLEND_W-1:0] mix_a, mix_b;
  logic                          v5, same5;
  logic [LEVEL_BITS+BLEND_W:0]   mix;

  assign cfg_ready = 1'b1;
  assign busy      = item_valid && (cmd == CMD_LOOKUP) && !phase;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_level <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
      phase      <= 1'b0;
    end else begin
      item_valid <= busy;
      phase      <= 1'b1;
    end
    if (accept) begin
      cmd    <= command;
      row    <= table_row;
      col    <= table_col;
      value  <= table_value;
      pa     <= pitch_a;
      ya     <= yaw_a;
      pb     <= pitch_b;
      yb     <= yaw_b;
      mp     <= model_pitch;
      my     <= model_yaw;
      weight <= (blend > BLEND_ONE) ? BLEND_ONE : blend;
    end
  end

  // Indices wrap by keeping the low bits of the two's complement sums.
  always_comb begin
    pn   = phase ? pb : pa;
    yn   = phase ? yb : ya;
    psum = {pn[ANGLE_W-1], pn} + {mp[ANGLE_W-1], mp};
    pabs = psum[ANGLE_W] ? -psum : psum;
    yabs = yn[ANGLE_W-1] ? -yn : yn;
    ysum = {2'b00, yabs} + {{2{my[ANGLE_W-1]}}, my};
    slot_next.valid  = item_valid;
    slot_next.wr     = (cmd == CMD_WRITE);
    slot_next.last   = phase;
    slot_next.same   = (pa == pb) && (ya == yb);
    slot_next.weight = weight;
    slot_next.wdata  = value;
    if (cmd == CMD_WRITE) begin
      slot_next.pidx  = row;
      slot_next.yidx  = col;
      slot_next.pfrac = '0;
      slot_next.yfrac = '0;
    end else begin
      slot_next.pidx  = pabs[FRAC_BITS+IDX_BITS-1:FRAC_BITS];
      slot_next.pfrac = pabs[FRAC_BITS-1:0];
      slot_next.yidx  = ysum[FRAC_BITS+IDX_BITS-1:FRAC_BITS];
      slot_next.yfrac = ysum[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.wr     <= slot_next.wr;
    slot.last   <= slot_next.last;
    slot.same   <= slot_next.same;
    slot.weight <= slot_next.weight;
    slot.pidx   <= slot_next.pidx;
    slot.pfrac  <= slot_next.pfrac;
    slot.yidx   <= slot_next.yidx;
    slot.yfrac  <= slot_next.yfrac;
    slot.wdata  <= slot_next.wdata;
  end

  ball_sampler u_sampler (
    .clk       (clk),
    .rst       (rst),
    .slot      (slot),
    .min_level (min_level),
    .samp      (samp)
  );

  // The first sample of a lookup is held until the second follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= samp.valid && samp.last;
    end
    if (samp.valid && !samp.last) begin
      l1_hold <= samp.level;
    end
    same5 <= samp.same;
    l1    <= l1_hold;
    mix_b <= samp.level * samp.weight;
    mix_a <= l1_hold * (BLEND_ONE - samp.weight);
  end

  assign mix = (LEVEL_BITS+BLEND_W+1)'(mix_a) + (LEVEL_BITS+BLEND_W+1)'(mix_b)
             + (LEVEL_BITS+BLEND_W+1)'(BLEND_ONE >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    light <= same5 ? l1 : mix[LEVEL_BITS+BLEND_W-2:BLEND_W-1];
  end

endmodule

`default_nettype wire
